FILE: src/joystick_valve_command_decoder_top_macros.svh
// Assertion macros for the joystick valve command decoder checker.
`ifndef JOYSTICK_VALVE_COMMAND_DECODER_TOP_MACROS_SVH
`define JOYSTICK_VALVE_COMMAND_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define JVCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define JVCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/jvcd_pkg.sv
// Shared types, constants and valve tables for the joystick valve command decoder.
package jvcd_pkg;

  typedef logic [16:0] btn_t;
  typedef logic [3:0]  seq_pos_t;
  typedef logic [1:0]  seq_cnt_t;

  localparam int unsigned BTN_L1 = 10;
  localparam int unsigned BTN_R1 = 11;

  localparam btn_t BTN_UP     = 17'h00010;
  localparam btn_t BTN_RIGHT  = 17'h00020;
  localparam btn_t BTN_DOWN   = 17'h00040;
  localparam btn_t BTN_LEFT   = 17'h00080;
  localparam btn_t BTN_CIRCLE = 17'h02000;
  localparam btn_t BTN_CROSS  = 17'h04000;

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_LEFT  = 3'd1;
  localparam logic [2:0] MODE_RIGHT = 3'd2;
  localparam logic [2:0] MODE_UP    = 3'd3;
  localparam logic [2:0] MODE_DOWN  = 3'd4;

  localparam logic REG_STICK_THRESHOLD  = 1'b0;
  localparam logic REG_MOTION_THRESHOLD = 1'b1;

  localparam logic [6:0] STICK_THRESHOLD_RST  = 7'd100;
  localparam logic [7:0] MOTION_THRESHOLD_RST = 8'd2;

  typedef struct packed {
    logic       change;
    logic       closing;
    logic [2:0] mode;
  } stick_evt_t;

  typedef struct packed {
    logic complete;
    logic dance;
  } seq_evt_t;

  function automatic logic [7:0] left_valves(input logic [2:0] m);
    logic [7:0] v;
    unique case (m)
      MODE_LEFT:  v = 8'h05;
      MODE_RIGHT: v = 8'h0A;
      MODE_UP:    v = 8'h11;
      MODE_DOWN:  v = 8'h22;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] right_valves(input logic [2:0] m);
    logic [7:0] v;
    unique case (m)
      MODE_LEFT:  v = 8'hA0;
      MODE_RIGHT: v = 8'h50;
      MODE_UP:    v = 8'h44;
      MODE_DOWN:  v = 8'h88;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: src/jvcd_seq.sv
// Ten-step button sequence detector with saturating completion count.
module jvcd_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  jvcd_pkg::btn_t    rel,
  output jvcd_pkg::seq_evt_t evt
);
  import jvcd_pkg::*;

  seq_pos_t pos, pos_next;
  seq_cnt_t cnt;
  logic     done;
  btn_t     rel_core;

  // Releases above cross come after the final step, so they only clear a position
  // that is already back at zero.
  assign rel_core = {2'b00, rel[14:0]};

  // Codes below the up button never match, and the sequence codes only rise in
  // runs of at most three, so the scan collapses to a few exact-mask compares.
  always_comb begin
    pos_next = '0;
    done     = 1'b0;
    if (rel == '0) begin
      pos_next = pos;
    end else if (|rel[3:0]) begin
      pos_next = (rel[16:4] == 13'h0001) ? 4'd1 : 4'd0;
    end else begin
      unique case (pos)
        4'd0: if (rel == BTN_UP) pos_next = 4'd1;
        4'd1: begin
          if (rel == BTN_UP) pos_next = 4'd2;
          else if (rel == (BTN_UP | BTN_DOWN)) pos_next = 4'd3;
        end
        4'd2: if (rel == BTN_DOWN) pos_next = 4'd3;
        4'd3: begin
          if (rel == BTN_DOWN) pos_next = 4'd4;
          else if (rel == (BTN_DOWN | BTN_LEFT)) pos_next = 4'd5;
        end
        4'd4: if (rel == BTN_LEFT) pos_next = 4'd5;
        4'd5: begin
          if (rel == BTN_RIGHT) pos_next = 4'd6;
          else if (rel == (BTN_RIGHT | BTN_LEFT)) pos_next = 4'd7;
        end
        4'd6: if (rel == BTN_LEFT) pos_next = 4'd7;
        4'd7: begin
          if (rel == BTN_RIGHT) pos_next = 4'd8;
          else if (rel == (BTN_RIGHT | BTN_CIRCLE)) pos_next = 4'd9;
          else if (rel_core == (BTN_RIGHT | BTN_CIRCLE | BTN_CROSS)) done = 1'b1;
        end
        4'd8: begin
          if (rel == BTN_CIRCLE) pos_next = 4'd9;
          else if (rel_core == (BTN_CIRCLE | BTN_CROSS)) done = 1'b1;
        end
        4'd9: if (rel_core == BTN_CROSS) done = 1'b1;
        default: pos_next = '0;
      endcase
    end
  end

  assign evt.complete = done;
  assign evt.dance    = done && (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cnt <= '0;
    end else if (step) begin
      pos <= pos_next;
      if (done && cnt != 2'd2) cnt <= cnt + 2'd1;
    end
  end

endmodule

FILE: src/jvcd_stick.sv
// Five-mode hysteresis machine for one stick, gated by motion and arming.
module jvcd_stick (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   active,
  input  logic [6:0]             stick_thr,
  input  logic [7:0]             motion_thr,
  input  logic signed [7:0]      x,
  input  logic signed [7:0]      y,
  input  logic signed [7:0]      dx,
  input  logic signed [7:0]      dy,
  output jvcd_pkg::stick_evt_t   evt
);
  import jvcd_pkg::*;

  logic [2:0]        mode, mode_next;
  logic [7:0]        adx, ady;
  logic [8:0]        motion;
  logic              moving;
  logic signed [8:0] xs, ys, tp, tn;
  logic              x_lo, x_hi, y_lo, y_hi;

  assign adx    = dx[7] ? (~dx + 8'd1) : dx;
  assign ady    = dy[7] ? (~dy + 8'd1) : dy;
  assign motion = {1'b0, adx} + {1'b0, ady};
  assign moving = motion > {1'b0, motion_thr};

  assign xs = {x[7], x};
  assign ys = {y[7], y};
  assign tp = $signed({2'b00, stick_thr});
  assign tn = -tp;

  assign x_lo = xs <= tn;
  assign x_hi = xs >= tp;
  assign y_lo = ys <= tn;
  assign y_hi = ys >= tp;

  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_NONE: begin
        if (x_lo) mode_next = MODE_LEFT;
        else if (x_hi) mode_next = MODE_RIGHT;
        else if (y_lo) mode_next = MODE_UP;
        else if (y_hi) mode_next = MODE_DOWN;
      end
      MODE_LEFT:  if (!x_lo) mode_next = MODE_NONE;
      MODE_RIGHT: if (!x_hi) mode_next = MODE_NONE;
      MODE_UP:    if (!y_lo) mode_next = MODE_NONE;
      MODE_DOWN:  if (!y_hi) mode_next = MODE_NONE;
      default:    mode_next = mode;
    endcase
  end

  assign evt.change  = active && moving && (mode_next != mode);
  assign evt.closing = (mode_next == MODE_NONE);
  assign evt.mode    = evt.closing ? mode : mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (step && active && moving) begin
      mode <= mode_next;
    end
  end

endmodule

FILE: src/joystick_valve_command_decoder_top.sv
// An accepted input beat is held in the input register, then in the result register.
// Throughput: one beat per cycle unless the master stalls; both registers advance together.
// The arming, sequence and stick state update in the cycle the input register hands on.
// Reset (rst, synchronous): armed, no stick modes, sequence and count cleared,
// thresholds back to 100 and 2, both registers empty.
module joystick_valve_command_decoder_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [7:0]   cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // buttons_held, buttons_released, left_x, left_y, left_dx, left_dy,
  // right_x, right_y, right_dx, right_dy, 6 bits of zero padding
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // valve_open_mask, valve_close_mask, armed, feedback_request,
  // sequence_complete, dance_request, 4 bits of zero padding
  output logic [23:0]  m_axis_tdata
);
  import jvcd_pkg::*;

  logic [6:0]  stick_thr;
  logic [7:0]  motion_thr;

  logic        in_valid;
  logic [97:0] in_data;
  logic        adv, fire;

  logic        out_valid;
  logic [19:0] out_data;

  logic        armed_flag, armed_next;
  logic        pair_held, both, toggle;

  btn_t        held, rel;
  seq_evt_t    seq_evt;
  stick_evt_t  l_evt, r_evt;
  logic [7:0]  lo, lc, ro, rc, open_mask, close_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_thr  <= STICK_THRESHOLD_RST;
      motion_thr <= MOTION_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STICK_THRESHOLD:  stick_thr  <= cfg_wdata[6:0];
        REG_MOTION_THRESHOLD: motion_thr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv           = !out_valid || m_axis_tready;
  assign fire          = in_valid && adv;
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_data <= s_axis_tdata[97:0];
  end

  assign held = in_data[16:0];
  assign rel  = in_data[33:17];

  assign both       = held[BTN_L1] && held[BTN_R1];
  assign toggle     = both && !pair_held;
  assign armed_next = armed_flag ^ toggle;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag <= 1'b1;
      pair_held  <= 1'b0;
    end else if (fire) begin
      armed_flag <= armed_next;
      pair_held  <= both;
    end
  end

  jvcd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (fire),
    .rel  (rel),
    .evt  (seq_evt)
  );

  jvcd_stick u_left (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .active     (armed_next),
    .stick_thr  (stick_thr),
    .motion_thr (motion_thr),
    .x          ($signed(in_data[41:34])),
    .y          ($signed(in_data[49:42])),
    .dx         ($signed(in_data[57:50])),
    .dy         ($signed(in_data[65:58])),
    .evt        (l_evt)
  );

  jvcd_stick u_right (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .active     (armed_next),
    .stick_thr  (stick_thr),
    .motion_thr (motion_thr),
    .x          ($signed(in_data[73:66])),
    .y          ($signed(in_data[81:74])),
    .dx         ($signed(in_data[89:82])),
    .dy         ($signed(in_data[97:90])),
    .evt        (r_evt)
  );

  assign lo = (l_evt.change && !l_evt.closing) ? left_valves(l_evt.mode)  : 8'h00;
  assign lc = (l_evt.change &&  l_evt.closing) ? left_valves(l_evt.mode)  : 8'h00;
  assign ro = (r_evt.change && !r_evt.closing) ? right_valves(r_evt.mode) : 8'h00;
  assign rc = (r_evt.change &&  r_evt.closing) ? right_valves(r_evt.mode) : 8'h00;

  // right stick wins
  assign open_mask  = (lo & ~rc) | ro;
  assign close_mask = (lc & ~ro) | rc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {seq_evt.dance, seq_evt.complete, toggle, armed_next,
                   close_mask, open_mask};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_data};

endmodule

FILE: src/jvcd_checker.sv
// Port-level checker for the joystick valve command decoder, bound to the top level.
`include "joystick_valve_command_decoder_top_macros.svh"

module jvcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `JVCD_ASSERT_IMP(a_masks_disjoint, m_axis_tvalid, (m_axis_tdata[7:0] & m_axis_tdata[15:8]) == 8'h00, "open and close masks overlap")
  `JVCD_ASSERT_IMP(a_disarmed_quiet, m_axis_tvalid && !m_axis_tdata[16], m_axis_tdata[15:0] == 16'h0000, "valves commanded while disarmed")
  `JVCD_ASSERT_IMP(a_dance_needs_done, m_axis_tvalid && m_axis_tdata[19], m_axis_tdata[18], "dance request without completion")
  `JVCD_ASSERT_NXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")

endmodule

bind joystick_valve_command_decoder_top jvcd_checker u_checker (.*);

FILE: test/joystick_valve_command_decoder_top_tb.sv
// Self-checking testbench for the joystick valve command decoder, with its own decoder prediction.
module joystick_valve_command_decoder_top_tb;
  import jvcd_pkg::*;

  typedef struct packed {
    logic [7:0] right_dy;
    logic [7:0] right_dx;
    logic [7:0] right_y;
    logic [7:0] right_x;
    logic [7:0] left_dy;
    logic [7:0] left_dx;
    logic [7:0] left_y;
    logic [7:0] left_x;
    btn_t       buttons_released;
    btn_t       buttons_held;
  } controller_event_t;

  typedef struct packed {
    logic       dance_request;
    logic       sequence_complete;
    logic       feedback_request;
    logic       armed;
    logic [7:0] valve_close_mask;
    logic [7:0] valve_open_mask;
  } valve_cmd_t;

  localparam int COMBO_LEN = 10;

  class valve_cmd_scoreboard;
    logic [6:0]  stick_thr;
    logic [7:0]  motion_thr;
    logic        armed_flag;
    logic        shoulder_held;
    logic [2:0]  left_mode;
    logic [2:0]  right_mode;
    int          seq_pos;
    int          completions;
    valve_cmd_t  pending_cmds[$];
    int          errors;
    int          beats_checked;
    int          combos_seen;
    int          dances_seen;
    int          toggles_seen;
    int          opens_seen;
    int          closes_seen;

    function new();
      stick_thr     = STICK_THRESHOLD_RST;
      motion_thr    = MOTION_THRESHOLD_RST;
      armed_flag    = 1'b1;
      shoulder_held = 1'b0;
      left_mode     = MODE_NONE;
      right_mode    = MODE_NONE;
      seq_pos       = 0;
      completions   = 0;
      errors        = 0;
      beats_checked = 0;
      combos_seen   = 0;
      dances_seen   = 0;
      toggles_seen  = 0;
      opens_seen    = 0;
      closes_seen   = 0;
    endfunction

    function void set_reg(logic addr, logic [7:0] value);
      if (addr == REG_STICK_THRESHOLD) begin
        stick_thr = value[6:0];
      end else begin
        motion_thr = value;
      end
    endfunction

    function btn_t combo_button(int pos);
      case (pos)
        0, 1:    return BTN_UP;
        2, 3:    return BTN_DOWN;
        4, 6:    return BTN_LEFT;
        5, 7:    return BTN_RIGHT;
        8:       return BTN_CIRCLE;
        9:       return BTN_CROSS;
        default: return '0;
      endcase
    endfunction

    // valve bits: FDin FDout RDin RDout FPin FPout RPin RPout from bit 0 up
    function logic [7:0] valve_pair(bit right_side, logic [2:0] m);
      case (m)
        MODE_LEFT:  return right_side ? 8'hA0 : 8'h05;
        MODE_RIGHT: return right_side ? 8'h50 : 8'h0A;
        MODE_UP:    return right_side ? 8'h44 : 8'h11;
        MODE_DOWN:  return right_side ? 8'h88 : 8'h22;
        default:    return 8'h00;
      endcase
    endfunction

    function logic [2:0] next_mode(logic [2:0] m, int x, int y);
      int t;
      t = stick_thr;
      case (m)
        MODE_NONE: begin
          if (x <= -t) return MODE_LEFT;
          if (x >= t) return MODE_RIGHT;
          if (y <= -t) return MODE_UP;
          if (y >= t) return MODE_DOWN;
          return MODE_NONE;
        end
        MODE_LEFT:  return (x > -t) ? MODE_NONE : m;
        MODE_RIGHT: return (x < t) ? MODE_NONE : m;
        MODE_UP:    return (y > -t) ? MODE_NONE : m;
        MODE_DOWN:  return (y < t) ? MODE_NONE : m;
        default:    return m;
      endcase
    endfunction

    function void step_stick(inout logic [2:0] m, input bit right_side,
                             input logic [7:0] x, y, dx, dy,
                             output logic [7:0] opn, cls);
      int ax, ay;
      logic [2:0] was;
      opn = 8'h00;
      cls = 8'h00;
      ax = $signed(dx);
      ay = $signed(dy);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (ax + ay <= int'(motion_thr)) return;
      was = m;
      m = next_mode(was, $signed(x), $signed(y));
      if (m == was) return;
      if (m == MODE_NONE) cls = valve_pair(right_side, was);
      else opn = valve_pair(right_side, m);
    endfunction

    function valve_cmd_t decode_event(controller_event_t ev);
      valve_cmd_t cmd;
      btn_t       want_btn;
      logic [7:0] lo, lc, ro, rc;
      cmd = '0;
      for (int i = 0; i < 17; i++) begin
        if (!ev.buttons_released[i]) continue;
        want_btn = combo_button(seq_pos);
        if (want_btn[i]) begin
          seq_pos++;
          if (seq_pos == COMBO_LEN) begin
            cmd.sequence_complete = 1'b1;
            if (completions < 2) completions++;
            seq_pos = 0;
            if (completions > 1) cmd.dance_request = 1'b1;
          end
        end else begin
          seq_pos = 0;
        end
      end
      if (ev.buttons_held[BTN_L1] && ev.buttons_held[BTN_R1]) begin
        if (!shoulder_held) begin
          armed_flag = !armed_flag;
          cmd.feedback_request = 1'b1;
        end
        shoulder_held = 1'b1;
      end else begin
        shoulder_held = 1'b0;
      end
      if (armed_flag) begin
        step_stick(left_mode, 1'b0, ev.left_x, ev.left_y, ev.left_dx, ev.left_dy, lo, lc);
        step_stick(right_mode, 1'b1, ev.right_x, ev.right_y, ev.right_dx, ev.right_dy,
                   ro, rc);
        // right stick takes precedence on shared valves
        cmd.valve_open_mask  = (lo & ~rc) | ro;
        cmd.valve_close_mask = (lc & ~ro) | rc;
      end
      cmd.armed = armed_flag;
      return cmd;
    endfunction

    function void note_event(controller_event_t ev);
      valve_cmd_t cmd;
      cmd = decode_event(ev);
      combos_seen  += cmd.sequence_complete;
      dances_seen  += cmd.dance_request;
      toggles_seen += cmd.feedback_request;
      opens_seen   += (cmd.valve_open_mask != 0);
      closes_seen  += (cmd.valve_close_mask != 0);
      pending_cmds.push_back(cmd);
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] data);
      valve_cmd_t got, want;
      got = data[19:0];
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %h", $time, data);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      beats_checked++;
      field_check("valve_open_mask", want.valve_open_mask, got.valve_open_mask);
      field_check("valve_close_mask", want.valve_close_mask, got.valve_close_mask);
      field_check("armed", want.armed, got.armed);
      field_check("feedback_request", want.feedback_request, got.feedback_request);
      field_check("sequence_complete", want.sequence_complete, got.sequence_complete);
      field_check("dance_request", want.dance_request, got.dance_request);
      field_check("padding", 0, data[23:20]);
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic          cfg_addr;
  logic [7:0]    cfg_wdata;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [23:0]   m_axis_tdata;

  valve_cmd_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;
  int events_sent;
  int settings_run;

  joystick_valve_command_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #400000;
    $display("%0t: timed out", $time);
    $display("Regression FAIL");
    $finish;
  end

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (64) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  function automatic controller_event_t quiet_event(btn_t held, btn_t released);
    controller_event_t ev;
    ev = '0;
    ev.buttons_held     = held;
    ev.buttons_released = released;
    return ev;
  endfunction

  function automatic logic [7:0] pick_position(int t);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(255);
      4, 5, 6: begin
        v = t - 1 + $urandom_range(2);
        if ($urandom_range(1)) v = -v;
      end
      7:       v = 0;
      default: v = $urandom_range(1) ? 127 : -128;
    endcase
    return v[7:0];
  endfunction

  function automatic logic [7:0] pick_delta();
    int v;
    if ($urandom_range(9) < 3) v = int'($urandom_range(6)) - 3;
    else v = $urandom_range(255);
    return v[7:0];
  endfunction

  function automatic controller_event_t random_event();
    controller_event_t ev;
    int r;
    int t;
    t = sb.stick_thr;
    ev.buttons_held = btn_t'($urandom());
    // mostly armed: re-arm often when disarmed, disarm rarely
    if ((!sb.armed_flag && $urandom_range(9) < 3) || (sb.armed_flag && $urandom_range(99) < 3))
    begin
      ev.buttons_held[BTN_L1] = 1'b1;
      ev.buttons_held[BTN_R1] = 1'b1;
    end else if ($urandom_range(1)) begin
      ev.buttons_held[BTN_L1] = 1'b0;
    end else begin
      ev.buttons_held[BTN_R1] = 1'b0;
    end
    r = $urandom_range(99);
    if (r < 82) ev.buttons_released = sb.combo_button(sb.seq_pos);
    else if (r < 88) ev.buttons_released = '0;
    else if (r < 94) ev.buttons_released = btn_t'(1) << $urandom_range(16);
    else ev.buttons_released = btn_t'($urandom());
    ev.left_x   = pick_position(t);
    ev.left_y   = pick_position(t);
    ev.left_dx  = pick_delta();
    ev.left_dy  = pick_delta();
    ev.right_x  = pick_position(t);
    ev.right_y  = pick_position(t);
    ev.right_dx = pick_delta();
    ev.right_dy = pick_delta();
    return ev;
  endfunction

  task automatic send_event(input controller_event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, ev};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_event(ev);
    events_sent++;
  endtask

  task automatic run_random(input int n, input int hold_at);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_off_req = 1'b1;
      send_event(random_event());
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_thresholds(input logic [7:0] stick, input logic [7:0] motion);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_STICK_THRESHOLD;
    cfg_wdata <= stick;
    @(posedge clk);
    sb.set_reg(REG_STICK_THRESHOLD, stick);
    cfg_addr  <= REG_MOTION_THRESHOLD;
    cfg_wdata <= motion;
    @(posedge clk);
    sb.set_reg(REG_MOTION_THRESHOLD, motion);
    cfg_we    <= 1'b0;
    settings_run++;
  endtask

  initial begin
    controller_event_t ev;
    btn_t shoulders;
    btn_t combo_beats[7];
    int   guard;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = REG_STICK_THRESHOLD;
    cfg_wdata     = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_off_req  = 1'b0;
    events_sent   = 0;
    settings_run  = 1;
    sb            = new();
    send_idle_pct = 29;
    recv_idle_pct = 52;
    shoulders     = (btn_t'(1) << BTN_L1) | (btn_t'(1) << BTN_R1);
    combo_beats   = '{BTN_UP, BTN_UP, BTN_DOWN, BTN_DOWN, BTN_LEFT, BTN_RIGHT | BTN_LEFT,
                      BTN_RIGHT | BTN_CIRCLE | BTN_CROSS};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_event(quiet_event('0, '0));
    // both sticks to horizontal extremes
    ev = quiet_event('0, '0);
    ev.left_x   = 8'h80;
    ev.left_dx  = 8'h80;
    ev.left_dy  = 8'h80;
    ev.right_x  = 8'h7F;
    ev.right_dx = 8'h7F;
    send_event(ev);
    // left back to centre, right left alone by no motion
    ev = quiet_event('0, '0);
    ev.left_dx = 8'd3;
    send_event(ev);
    // motion equal to threshold is not enough
    ev = quiet_event('0, '0);
    ev.right_dx = 8'd1;
    ev.right_dy = 8'hFF;
    send_event(ev);
    ev.right_dy = 8'hFE;
    send_event(ev);
    ev = quiet_event('0, '0);
    ev.right_x  = 8'd100;
    ev.right_dx = 8'd5;
    send_event(ev);
    // left opens up-pair while right closes, shared valve goes to right
    ev = quiet_event('0, '0);
    ev.left_y   = 8'h9C;
    ev.left_dy  = 8'hFB;
    ev.right_x  = 8'd99;
    ev.right_dx = 8'd5;
    send_event(ev);
    // up to full down: returns to none, no direct swap
    ev = quiet_event('0, '0);
    ev.left_y  = 8'h7F;
    ev.left_dy = 8'h7F;
    send_event(ev);
    // disarm with every button, sticks ignored
    ev = quiet_event('1, '1);
    ev.left_x   = 8'h80;
    ev.left_dx  = 8'h80;
    ev.right_y  = 8'h80;
    ev.right_dy = 8'h80;
    send_event(ev);
    send_event(ev);
    ev.buttons_held = '0;
    ev.buttons_released = '0;
    send_event(ev);
    send_event(quiet_event(shoulders, '0));
    // third up release restarts and does not count as a first step
    send_event(quiet_event('0, BTN_UP));
    send_event(quiet_event('0, BTN_UP));
    send_event(quiet_event('0, BTN_UP));
    foreach (combo_beats[i]) send_event(quiet_event('0, combo_beats[i]));

    run_random(270, -1);
    drain();
    write_thresholds(8'd0, 8'd0);
    send_idle_pct = 52;
    recv_idle_pct = 29;
    run_random(280, -1);
    drain();
    write_thresholds(8'hFF, 8'hFF);
    run_random(150, -1);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_thresholds(8'($urandom_range(127, 1)), 8'($urandom_range(20)));
    run_random(300, 100);
    drain();
    write_thresholds(8'd1, 8'd1);
    run_random(140, -1);
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (sb.pending_cmds.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (sb.pending_cmds.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_cmds.size());
      sb.errors++;
    end
    $display("%0d controller events over %0d threshold settings, %0d results checked",
             events_sent, settings_run, sb.beats_checked);
    $display("%0d combos, %0d dance requests, %0d arm toggles, %0d opens, %0d closes",
             sb.combos_seen, sb.dances_seen, sb.toggles_seen, sb.opens_seen, sb.closes_seen);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
